/* sv/wavh_pkg.sv */
// Shared types, constants and header lookup for the WAV header checker.
package wavh_pkg;

  // Parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  // Header byte positions
  localparam logic [5:0] POS_CHANNELS = 6'd22;
  localparam logic [5:0] POS_RATE_LO  = 6'd24;
  localparam logic [5:0] POS_RATE_HI  = 6'd25;
  localparam logic [5:0] POS_BITS     = 6'd34;
  localparam logic [5:0] POS_SIZE_B0  = 6'd40;
  localparam logic [5:0] POS_SIZE_B1  = 6'd41;
  localparam logic [5:0] POS_SIZE_B2  = 6'd42;
  localparam logic [5:0] POS_SIZE_B3  = 6'd43;
  localparam logic [5:0] HEADER_LAST  = 6'd43;

  // Header values the file must carry, and the reset value of the expected rate
  localparam logic [7:0]  WANT_CHANNELS = 8'd2;
  localparam logic [7:0]  WANT_BITS     = 8'd16;
  localparam logic [31:0] MIN_DATA_SIZE = 32'd468;
  localparam logic [15:0] RATE_RESET    = 16'd44100;

  // Result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_SAMPLE  = 1'b1;

  // Configuration register index
  localparam logic REG_EXPECTED_RATE = 1'b0;

  typedef struct packed {
    logic        result_kind;
    logic        header_ok;
    logic [15:0] sample_rate;
    logic [31:0] data_size;
    logic [31:0] sample_word;
    logic        last_word;
  } result_t;

  // Flag a byte that differs from the fixed value at its header position
  function automatic logic fixed_mismatch(input logic [5:0] pos, input logic [7:0] b);
    logic m;
    case (pos)
      6'd8:    m = (b != 8'h57);  // 'W'
      6'd9:    m = (b != 8'h41);  // 'A'
      6'd10:   m = (b != 8'h56);  // 'V'
      6'd11:   m = (b != 8'h45);  // 'E'
      6'd20:   m = (b != 8'h01);  // PCM format code
      6'd36:   m = (b != 8'h64);  // 'd'
      6'd37:   m = (b != 8'h61);  // 'a'
      6'd38:   m = (b != 8'h74);  // 't'
      6'd39:   m = (b != 8'h61);  // 'a'
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

/* sv/wav_header_check_and_sample_feed.sv */
// Top level: WAV header checker and stereo sample feeder with APB rate register.
//
// Takes one file byte per clock on the input channel, checks the 44-byte WAV
// header and emits a verdict on header byte 43 (or a rejection on an early
// end of file); after a good header it packs each four data bytes into one
// stereo word, floor(data_size/4) words in all, the final one flagged. Each
// result is registered into the output register, or into the skid register
// while the output is held; a two-deep output register lets the input keep
// flowing while one result waits, so the rate is one byte per clock as long
// as results are taken. end_of_file re-arms for the next file.
// The expected sample rate is written over APB at address 0 (reset 44100).
module wav_header_check_and_sample_feed import wavh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic        header_ok,
  output logic [15:0] sample_rate,
  output logic [31:0] data_size,
  output logic [31:0] sample_word,
  output logic        last_word
);

  logic [15:0] expected_rate;
  logic        reg_index;
  logic        accept;
  logic        push;
  logic        full;
  result_t     push_data;
  result_t     out_data;

  // Decode the register index from the byte address
  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  // Write the rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate <= RATE_RESET;
    end else if (psel && penable && pwrite && (reg_index == REG_EXPECTED_RATE)) begin
      expected_rate <= pwdata[15:0];
    end
  end

  // Read back the rate register
  always_comb begin
    prdata = '0;
    if (reg_index == REG_EXPECTED_RATE) prdata = {16'd0, expected_rate};
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  wavh_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .file_byte     (file_byte),
    .end_of_file   (end_of_file),
    .expected_rate (expected_rate),
    .push          (push),
    .result        (push_data)
  );

  wavh_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign result_kind = out_data.result_kind;
  assign header_ok   = out_data.header_ok;
  assign sample_rate = out_data.sample_rate;
  assign data_size   = out_data.data_size;
  assign sample_word = out_data.sample_word;
  assign last_word   = out_data.last_word;

endmodule

/* sv/wavh_parse.sv */
// Header parser and sample packer: captures, checks and word assembly per byte.
module wavh_parse import wavh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  input  logic [15:0] expected_rate,
  output logic        push,
  output result_t     result
);

  logic [1:0]  phase, phase_next;
  logic [5:0]  byte_position, byte_position_next;
  logic        header_failed, header_failed_next;
  logic [7:0]  channel_capture, channel_capture_next;
  logic [15:0] rate_capture, rate_capture_next;
  logic [7:0]  bits_capture, bits_capture_next;
  logic [31:0] size_capture, size_capture_next;
  logic [23:0] word_assembly, word_assembly_next;
  logic [1:0]  byte_lane, byte_lane_next;
  logic [29:0] words_left, words_left_next;
  logic        ok;

  // Compute the next state and the result for the byte at the input
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    header_failed_next   = header_failed;
    channel_capture_next = channel_capture;
    rate_capture_next    = rate_capture;
    bits_capture_next    = bits_capture;
    size_capture_next    = size_capture;
    word_assembly_next   = word_assembly;
    byte_lane_next       = byte_lane;
    words_left_next      = words_left;
    push                 = 1'b0;
    ok                   = 1'b0;
    result               = '0;

    case (phase)
      PH_HEADER: begin
        if (fixed_mismatch(byte_position, file_byte)) header_failed_next = 1'b1;
        case (byte_position)
          POS_CHANNELS: channel_capture_next = file_byte;
          POS_RATE_LO:  rate_capture_next[7:0] = file_byte;
          POS_RATE_HI:  rate_capture_next[15:8] = file_byte;
          POS_BITS:     bits_capture_next = file_byte;
          POS_SIZE_B0:  size_capture_next[7:0] = size_capture[7:0] | file_byte;
          POS_SIZE_B1:  size_capture_next[15:8] = size_capture[15:8] | file_byte;
          POS_SIZE_B2:  size_capture_next[23:16] = size_capture[23:16] | file_byte;
          POS_SIZE_B3:  size_capture_next[31:24] = size_capture[31:24] | file_byte;
          default: ;
        endcase

        result.result_kind = KIND_VERDICT;
        result.sample_rate = rate_capture_next;
        result.data_size   = size_capture_next;

        if (byte_position >= HEADER_LAST) begin
          ok = !header_failed_next && (channel_capture_next == WANT_CHANNELS) &&
               (bits_capture_next == WANT_BITS) &&
               (rate_capture_next == expected_rate) &&
               (size_capture_next >= MIN_DATA_SIZE);
          push = 1'b1;
          result.header_ok = ok;
          if (ok) begin
            phase_next         = PH_DATA;
            words_left_next    = size_capture_next[31:2];
            word_assembly_next = '0;
            byte_lane_next     = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end else if (end_of_file) begin
          push = 1'b1;
        end else begin
          byte_position_next = byte_position + 6'd1;
        end
      end

      PH_DATA: begin
        case (byte_lane)
          2'd0: begin
            word_assembly_next[7:0] = file_byte;
            byte_lane_next = 2'd1;
          end
          2'd1: begin
            word_assembly_next[15:8] = file_byte;
            byte_lane_next = 2'd2;
          end
          2'd2: begin
            word_assembly_next[23:16] = file_byte;
            byte_lane_next = 2'd3;
          end
          default: begin
            // Complete the word and count it off
            words_left_next    = words_left - 30'd1;
            push               = 1'b1;
            result.result_kind = KIND_SAMPLE;
            result.sample_word = {file_byte, word_assembly};
            result.last_word   = (words_left_next == '0);
            word_assembly_next = '0;
            byte_lane_next     = '0;
            if (words_left_next == '0) phase_next = PH_SKIP;
          end
        endcase
      end

      // Skip phase and the unused code: drop the byte
      default: ;
    endcase

    // Re-arm for the next file
    if (end_of_file) begin
      phase_next           = PH_HEADER;
      byte_position_next   = '0;
      header_failed_next   = 1'b0;
      channel_capture_next = '0;
      rate_capture_next    = '0;
      bits_capture_next    = '0;
      size_capture_next    = '0;
      word_assembly_next   = '0;
      byte_lane_next       = '0;
      words_left_next      = '0;
    end
  end

  // Advance the parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      header_failed   <= 1'b0;
      channel_capture <= '0;
      rate_capture    <= '0;
      bits_capture    <= '0;
      size_capture    <= '0;
      word_assembly   <= '0;
      byte_lane       <= '0;
      words_left      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      header_failed   <= header_failed_next;
      channel_capture <= channel_capture_next;
      rate_capture    <= rate_capture_next;
      bits_capture    <= bits_capture_next;
      size_capture    <= size_capture_next;
      word_assembly   <= word_assembly_next;
      byte_lane       <= byte_lane_next;
      words_left      <= words_left_next;
    end
  end

endmodule

/* sv/wavh_skid.sv */
// Output register with a skid stage so input acceptance waits on out_stall only when the skid stage is full.
module wavh_skid import wavh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Hold control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) skid_valid <= 1'b1;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Move payload: skid drains first, else new transaction fills the free slot
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || pop) out_data <= push_data;
      else skid_data <= push_data;
    end
  end

endmodule
